>>> hdl/dppb_pkg.sv
// Package with the item types, register indexes and defaults of the depth point plane binarizer.
package dppb_pkg;

  localparam int FRAC_BITS_DEF  = 24;
  localparam int MAP_WIDTH_DEF  = 640;
  localparam int MAP_HEIGHT_DEF = 480;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_REGS   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_0      = 3'd0,
    REG_MATRIX_1      = 3'd1,
    REG_MATRIX_2      = 3'd2,
    REG_MATRIX_3      = 3'd3,
    REG_MATRIX_OFS_4  = 3'd4,
    REG_OFS_5         = 3'd5,
    REG_BOX_LIMITS    = 3'd6,
    REG_WINDOW_UNITS  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  pixel_column;
    logic [9:0]  pixel_row;
    logic [15:0] depth_value;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [9:0] map_x;
    logic [9:0] map_y;
  } out_item_t;

endpackage

>>> hdl/depth_point_plane_binarizer.sv
// Top level of the depth point plane binarizer: window check, affine transform and box test.
//
// One item is accepted per cycle while in_stall is low, and each yields one result through a
// six-stage pipeline (input and window, nine products, sums, box test, unit scaling, output
// register). Each stage moves on when it is empty or the stage after it moves, so a stall on the
// result side fills the pipeline before in_stall rises. Configuration is written through cfg_*
// with cfg_ready always high and must only change while no item is in flight.
module depth_point_plane_binarizer #(
  parameter int FRAC_BITS  = dppb_pkg::FRAC_BITS_DEF,
  parameter int MAP_WIDTH  = dppb_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = dppb_pkg::MAP_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dppb_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dppb_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dppb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dppb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dppb_pkg::*;

  localparam int C_W  = 42;
  localparam int D_W  = 48;
  localparam int T_W  = 51;
  localparam int PX_W = FRAC_BITS + 12;
  localparam int PY_W = 43;
  localparam int MY_W = PY_W - FRAC_BITS;
  localparam logic signed [T_W-1:0] ONE = $signed(T_W'(64'd1 << FRAC_BITS));

  logic [CFG_DATA_W-1:0] cfg_r [NUM_REGS];

  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [31:0] ox, oy, oz, ylim, zlim;
  logic [9:0]  wx0, wx1, wy0, wy1;
  logic [11:0] xu, yu;

  logic en1, en2, en3, en4, en5, en_out;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  logic            s1_win_r, s1_win_nxt;
  logic [9:0]      s1_col_r, s1_row_r;
  logic [15:0]     s1_dep_r;

  logic                  s2_win_r;
  logic signed [C_W-1:0] s2_pc_r [3];
  logic signed [C_W-1:0] s2_pr_r [3];
  logic signed [D_W-1:0] s2_pd_r [3];
  logic signed [C_W-1:0] s2_pc_nxt [3];
  logic signed [C_W-1:0] s2_pr_nxt [3];
  logic signed [D_W-1:0] s2_pd_nxt [3];

  logic                  s3_win_r;
  logic signed [T_W-1:0] s3_t_r [3];
  logic signed [T_W-1:0] s3_t_nxt [3];

  logic                  s4_ok_r, s4_ok_nxt;
  logic [FRAC_BITS-1:0]  s4_t0f_r;
  logic [30:0]           s4_ydiff_r;
  logic signed [T_W-1:0] ylim_ext, zlim_ext, ydiff_full;

  logic             s5_ok_r;
  logic [PX_W-1:0]  s5_px_r;
  logic [PY_W-1:0]  s5_py_r;

  logic [11:0]      mx;
  logic [MY_W-1:0]  my;
  out_item_t        out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    m00  = $signed(cfg_r[REG_MATRIX_0][31:0]);
    m01  = $signed(cfg_r[REG_MATRIX_0][63:32]);
    m02  = $signed(cfg_r[REG_MATRIX_1][31:0]);
    m10  = $signed(cfg_r[REG_MATRIX_1][63:32]);
    m11  = $signed(cfg_r[REG_MATRIX_2][31:0]);
    m12  = $signed(cfg_r[REG_MATRIX_2][63:32]);
    m20  = $signed(cfg_r[REG_MATRIX_3][31:0]);
    m21  = $signed(cfg_r[REG_MATRIX_3][63:32]);
    m22  = $signed(cfg_r[REG_MATRIX_OFS_4][31:0]);
    ox   = $signed(cfg_r[REG_MATRIX_OFS_4][63:32]);
    oy   = $signed(cfg_r[REG_OFS_5][31:0]);
    oz   = $signed(cfg_r[REG_OFS_5][63:32]);
    ylim = $signed(cfg_r[REG_BOX_LIMITS][31:0]);
    zlim = $signed(cfg_r[REG_BOX_LIMITS][63:32]);
    wx0  = cfg_r[REG_WINDOW_UNITS][9:0];
    wx1  = cfg_r[REG_WINDOW_UNITS][19:10];
    wy0  = cfg_r[REG_WINDOW_UNITS][29:20];
    wy1  = cfg_r[REG_WINDOW_UNITS][39:30];
    xu   = cfg_r[REG_WINDOW_UNITS][51:40];
    yu   = cfg_r[REG_WINDOW_UNITS][63:52];
  end

  assign en_out   = !out_valid_r || !out_stall;
  assign en5      = !v5_r || en_out;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en5)    v5_r        <= v4_r;
      if (en_out) out_valid_r <= v5_r;
    end
  end

  always_comb begin
    s1_win_nxt = (in_data.pixel_column >= wx0) && (in_data.pixel_column < wx1) &&
                 (in_data.pixel_row >= wy0) && (in_data.pixel_row < wy1) &&
                 (in_data.depth_value != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_win_r <= s1_win_nxt;
      s1_col_r <= in_data.pixel_column;
      s1_row_r <= in_data.pixel_row;
      s1_dep_r <= in_data.depth_value;
    end
  end

  always_comb begin
    logic signed [C_W-1:0] c_ext, r_ext;
    logic signed [D_W-1:0] d_ext;
    c_ext = $signed(C_W'(s1_col_r));
    r_ext = $signed(C_W'(s1_row_r));
    d_ext = $signed(D_W'(s1_dep_r));
    s2_pc_nxt[0] = C_W'(m00) * c_ext;
    s2_pr_nxt[0] = C_W'(m01) * r_ext;
    s2_pd_nxt[0] = D_W'(m02) * d_ext;
    s2_pc_nxt[1] = C_W'(m10) * c_ext;
    s2_pr_nxt[1] = C_W'(m11) * r_ext;
    s2_pd_nxt[1] = D_W'(m12) * d_ext;
    s2_pc_nxt[2] = C_W'(m20) * c_ext;
    s2_pr_nxt[2] = C_W'(m21) * r_ext;
    s2_pd_nxt[2] = D_W'(m22) * d_ext;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_win_r <= s1_win_r;
      for (int i = 0; i < 3; i++) begin
        s2_pc_r[i] <= s2_pc_nxt[i];
        s2_pr_r[i] <= s2_pr_nxt[i];
        s2_pd_r[i] <= s2_pd_nxt[i];
      end
    end
  end

  always_comb begin
    s3_t_nxt[0] = T_W'(s2_pc_r[0]) + T_W'(s2_pr_r[0]) + T_W'(s2_pd_r[0]) + T_W'(ox);
    s3_t_nxt[1] = T_W'(s2_pc_r[1]) + T_W'(s2_pr_r[1]) + T_W'(s2_pd_r[1]) + T_W'(oy);
    s3_t_nxt[2] = T_W'(s2_pc_r[2]) + T_W'(s2_pr_r[2]) + T_W'(s2_pd_r[2]) + T_W'(oz);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_win_r <= s2_win_r;
      for (int i = 0; i < 3; i++) s3_t_r[i] <= s3_t_nxt[i];
    end
  end

  always_comb begin
    ylim_ext   = T_W'(ylim);
    zlim_ext   = T_W'(zlim);
    ydiff_full = ylim_ext - s3_t_r[1];
    s4_ok_nxt  = s3_win_r &&
                 (s3_t_r[0] > 0) && (s3_t_r[1] > 0) && (s3_t_r[2] > 0) &&
                 (s3_t_r[0] < ONE) && (s3_t_r[1] < ylim_ext) && (s3_t_r[2] < zlim_ext);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_ok_r    <= s4_ok_nxt;
      s4_t0f_r   <= s3_t_r[0][FRAC_BITS-1:0];
      s4_ydiff_r <= ydiff_full[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_ok_r <= s4_ok_r;
      s5_px_r <= PX_W'(s4_t0f_r) * PX_W'(xu);
      s5_py_r <= PY_W'(s4_ydiff_r) * PY_W'(yu);
    end
  end

  always_comb begin
    mx = s5_px_r[PX_W-1:FRAC_BITS];
    my = s5_py_r[PY_W-1:FRAC_BITS];
    out_data_nxt = '0;
    if (s5_ok_r && (mx < 12'(MAP_WIDTH)) && (my < MY_W'(MAP_HEIGHT))) begin
      out_data_nxt.hit   = 1'b1;
      out_data_nxt.map_x = mx[9:0];
      out_data_nxt.map_y = my[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && v1_r && v2_r && v3_r && v4_r && v5_r))
    else $error("input stalled while the pipeline has room");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.map_x == 10'd0 && out_data.map_y == 10'd0))
    else $error("map cell not zero on a miss");

  a_hit_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |->
      (11'(out_data.map_x) < 11'(MAP_WIDTH) && 11'(out_data.map_y) < 11'(MAP_HEIGHT)))
    else $error("hit outside the map");

endmodule

>>> tb/dppb_checker.sv
// Checker for the depth point plane binarizer: predicts each map cell and compares it.
`timescale 1ns / 1ps
module dppb_checker #(
  parameter int FRAC_BITS  = dppb_pkg::FRAC_BITS_DEF,
  parameter int MAP_WIDTH  = dppb_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = dppb_pkg::MAP_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  dppb_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  dppb_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dppb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dppb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import dppb_pkg::*;

  logic [63:0] shadow_regs [NUM_REGS];
  out_item_t   expected_cells [$];
  int          pixels_seen;
  int          cells_seen;

  assign pending = pixels_seen - cells_seen;

  function automatic longint half_word(logic [63:0] word, bit upper);
    if (upper) begin
      return longint'($signed(word[63:32]));
    end
    return longint'($signed(word[31:0]));
  endfunction

  function automatic out_item_t mark_cell(in_item_t px);
    longint col, row, dep, one, ylim, zlim, xu, yu, t0, t1, t2, mx, my;
    logic [63:0] win;
    out_item_t res;
    res = '0;
    col  = longint'(px.pixel_column);
    row  = longint'(px.pixel_row);
    dep  = longint'(px.depth_value);
    win  = shadow_regs[REG_WINDOW_UNITS];
    if (col < longint'(win[9:0]) || col >= longint'(win[19:10]) ||
        row < longint'(win[29:20]) || row >= longint'(win[39:30]) || dep == 0) begin
      return res;
    end
    t0 = half_word(shadow_regs[REG_MATRIX_0], 1'b0) * col +
         half_word(shadow_regs[REG_MATRIX_0], 1'b1) * row +
         half_word(shadow_regs[REG_MATRIX_1], 1'b0) * dep +
         half_word(shadow_regs[REG_MATRIX_OFS_4], 1'b1);
    t1 = half_word(shadow_regs[REG_MATRIX_1], 1'b1) * col +
         half_word(shadow_regs[REG_MATRIX_2], 1'b0) * row +
         half_word(shadow_regs[REG_MATRIX_2], 1'b1) * dep +
         half_word(shadow_regs[REG_OFS_5], 1'b0);
    t2 = half_word(shadow_regs[REG_MATRIX_3], 1'b0) * col +
         half_word(shadow_regs[REG_MATRIX_3], 1'b1) * row +
         half_word(shadow_regs[REG_MATRIX_OFS_4], 1'b0) * dep +
         half_word(shadow_regs[REG_OFS_5], 1'b1);
    one  = longint'(1) <<< FRAC_BITS;
    ylim = half_word(shadow_regs[REG_BOX_LIMITS], 1'b0);
    zlim = half_word(shadow_regs[REG_BOX_LIMITS], 1'b1);
    if (t0 <= 0 || t1 <= 0 || t2 <= 0 || t0 >= one || t1 >= ylim || t2 >= zlim) begin
      return res;
    end
    xu = longint'(win[51:40]);
    yu = longint'(win[63:52]);
    mx = (t0 * xu) >>> FRAC_BITS;
    my = ((ylim - t1) * yu) >>> FRAC_BITS;
    if (mx >= MAP_WIDTH || my >= MAP_HEIGHT) begin
      return res;
    end
    res.hit   = 1'b1;
    res.map_x = 10'(mx);
    res.map_y = 10'(my);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      foreach (shadow_regs[i]) shadow_regs[i] <= '0;
      expected_cells.delete();
      pixels_seen <= 0;
      cells_seen  <= 0;
      fail_count  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        cells_seen <= cells_seen + 1;
        if (expected_cells.size() == 0) begin
          $display("%0t: result with nothing expected: hit %0b x %0d y %0d", $time,
                   out_data.hit, out_data.map_x, out_data.map_y);
          errs++;
        end else begin
          want = expected_cells.pop_front();
          if (out_data.hit !== want.hit) begin
            $display("%0t: hit expected %0b, got %0b", $time, want.hit, out_data.hit);
            errs++;
          end
          if (out_data.map_x !== want.map_x) begin
            $display("%0t: map_x expected %0d, got %0d", $time, want.map_x, out_data.map_x);
            errs++;
          end
          if (out_data.map_y !== want.map_y) begin
            $display("%0t: map_y expected %0d, got %0d", $time, want.map_y, out_data.map_y);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_cells.insert(expected_cells.size(), mark_cell(in_data));
        pixels_seen <= pixels_seen + 1;
      end
      if (cfg_valid && cfg_ready) begin
        shadow_regs[cfg_index] <= cfg_data;
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the depth point plane binarizer testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import dppb_pkg::*;

  localparam int ONE          = 1 << FRAC_BITS_DEF;
  localparam int MAX_POS      = 32'sh7FFF_FFFF;
  localparam int MIN_NEG      = 32'sh8000_0000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 10;

  typedef enum {
    SET_NOMINAL, SET_JITTER, SET_ZERO_UNITS, SET_BIG_UNITS,
    SET_ALL_ONES, SET_CORNER_COEFS, SET_NEG_LIMITS, SET_EMPTY_WINDOW
  } setting_kind_t;

  typedef enum { STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    pixels_sent = 0;
  logic [63:0]           settings [NUM_REGS];
  stall_mode_t           stall_mode = STALL_NONE;
  int                    stall_left = 0;

  depth_point_plane_binarizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dppb_checker cell_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left > 8);
    endcase
  end

  function automatic int spread(int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic logic [63:0] pair(int lo, int hi);
    return {hi, lo};
  endfunction

  function automatic logic [63:0] window_word(int x0, int x1, int y0, int y1, int xu, int yu);
    return {12'(yu), 12'(xu), 10'(y1), 10'(y0), 10'(x1), 10'(x0)};
  endfunction

  function automatic setting_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return SET_JITTER;
    if (r < 65) return SET_NOMINAL;
    if (r < 71) return SET_ZERO_UNITS;
    if (r < 77) return SET_BIG_UNITS;
    if (r < 83) return SET_CORNER_COEFS;
    if (r < 88) return SET_NEG_LIMITS;
    if (r < 94) return SET_EMPTY_WINDOW;
    return SET_ALL_ONES;
  endfunction

  task automatic build_settings(input setting_kind_t kind);
    int ylim, zlim, x0, x1, y0, y1, xu, yu;
    settings[REG_MATRIX_0]     = pair(ONE >>> 10, 0);
    settings[REG_MATRIX_1]     = pair(0, 0);
    settings[REG_MATRIX_2]     = pair(ONE >>> 10, 0);
    settings[REG_MATRIX_3]     = pair(0, 0);
    settings[REG_MATRIX_OFS_4] = pair(ONE >>> 16, ONE >>> 12);
    settings[REG_OFS_5]        = pair(ONE >>> 12, ONE >>> 12);
    settings[REG_BOX_LIMITS]   = pair(ONE, ONE);
    settings[REG_WINDOW_UNITS] = window_word(0, 1023, 0, 1023, 640, 480);
    case (kind)
      SET_JITTER: begin
        ylim = $urandom_range(ONE >>> 2, ONE <<< 2);
        zlim = $urandom_range(ONE >>> 2, ONE <<< 2);
        settings[REG_MATRIX_0]     = pair((ONE >>> 10) + spread(1 << 11), spread(1 << 6));
        settings[REG_MATRIX_1]     = pair(spread(1 << 6), spread(1 << 6));
        settings[REG_MATRIX_2]     = pair((ylim >>> 10) + spread(1 << 8), spread(1 << 6));
        settings[REG_MATRIX_3]     = pair(spread(1 << 6), spread(1 << 6));
        settings[REG_MATRIX_OFS_4] = pair((zlim >>> 16) + spread(32), spread(ONE >>> 4));
        settings[REG_OFS_5]        = pair(spread(ylim >>> 4), spread(zlim >>> 4));
        settings[REG_BOX_LIMITS]   = pair(ylim, zlim);
        x0 = $urandom_range(0, 300);
        x1 = $urandom_range(x0, 1023);
        y0 = $urandom_range(0, 300);
        y1 = $urandom_range(y0, 1023);
        xu = $urandom_range(0, 1) ? $urandom_range(300, 700) : $urandom_range(0, 4095);
        yu = $urandom_range(0, 1) ? $urandom_range(300, 700) : $urandom_range(0, 4095);
        settings[REG_WINDOW_UNITS] = window_word(x0, x1, y0, y1, xu, yu);
      end
      SET_ZERO_UNITS: settings[REG_WINDOW_UNITS] = window_word(0, 1023, 0, 1023, 0, 0);
      SET_BIG_UNITS: settings[REG_WINDOW_UNITS] = window_word(0, 1023, 0, 1023, 4095, 4095);
      SET_ALL_ONES: begin
        foreach (settings[i]) settings[i] = '1;
      end
      SET_CORNER_COEFS: begin
        settings[REG_MATRIX_0]     = pair(MAX_POS, MIN_NEG);
        settings[REG_MATRIX_1]     = pair(MIN_NEG, MAX_POS);
        settings[REG_MATRIX_2]     = pair(MAX_POS, MIN_NEG);
        settings[REG_MATRIX_3]     = pair(MIN_NEG, MAX_POS);
        settings[REG_MATRIX_OFS_4] = pair(MAX_POS, MIN_NEG);
        settings[REG_OFS_5]        = pair(MAX_POS, MIN_NEG);
        settings[REG_BOX_LIMITS]   = pair(MAX_POS, MAX_POS);
        settings[REG_WINDOW_UNITS] = window_word(0, 1023, 0, 1023, 4095, 4095);
      end
      SET_NEG_LIMITS: begin
        case ($urandom_range(0, 2))
          0:       settings[REG_BOX_LIMITS] = pair(0, ONE);
          1:       settings[REG_BOX_LIMITS] = pair(ONE, -int'($urandom_range(1, ONE)));
          default: settings[REG_BOX_LIMITS] = pair(MIN_NEG, 0);
        endcase
      end
      SET_EMPTY_WINDOW: begin
        x0 = $urandom_range(0, 1023);
        y0 = $urandom_range(0, 1023);
        if ($urandom_range(0, 1)) begin
          settings[REG_WINDOW_UNITS] = window_word(x0, $urandom_range(0, x0), 0, 1023, 640, 480);
        end else begin
          settings[REG_WINDOW_UNITS] = window_word(0, 1023, y0, $urandom_range(0, y0), 640, 480);
        end
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input setting_kind_t kind);
    cfg_reg_t idx;
    build_settings(kind);
    wait_idle();
    idx = idx.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= settings[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input in_item_t px);
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic in_item_t random_pixel();
    logic [63:0] win;
    in_item_t px;
    win = settings[REG_WINDOW_UNITS];
    px.pixel_column = 10'($urandom);
    px.pixel_row    = 10'($urandom);
    px.depth_value  = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      if (win[19:10] > win[9:0]) begin
        px.pixel_column = 10'($urandom_range(win[9:0], win[19:10] - 1));
      end
      if (win[39:30] > win[29:20]) begin
        px.pixel_row = 10'($urandom_range(win[29:20], win[39:30] - 1));
      end
      if (px.depth_value == 0) px.depth_value = 16'd1;
    end else if ($urandom_range(0, 2) == 0) begin
      px.depth_value = '0;
    end
    return px;
  endfunction

  task automatic send_phase(input int count);
    int burst, gap;
    while (count > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      for (int k = 0; k < burst && count > 0; k++) begin
        send_pixel(random_pixel());
        count--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 29) == 0) begin
        wait_idle();
      end else if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic probe(input setting_kind_t kind, input int first, input int count);
    in_item_t probes [8];
    probes = '{
      in_item_t'{10'd0,    10'd0,    16'd1},
      in_item_t'{10'd1023, 10'd1023, 16'd65535},
      in_item_t'{10'd0,    10'd1023, 16'd0},
      in_item_t'{10'd1023, 10'd0,    16'd65535},
      in_item_t'{10'd512,  10'd512,  16'd32768},
      in_item_t'{10'd1,    10'd1,    16'd1},
      in_item_t'{10'd1022, 10'd1022, 16'd65535},
      in_item_t'{10'd700,  10'd300,  16'd40000}
    };
    load_settings(kind);
    for (int k = first; k < first + count; k++) begin
      send_pixel(probes[k]);
    end
  endtask

  initial begin
    int goal;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset value leave the window empty.
    send_pixel(in_item_t'{10'd0, 10'd0, 16'd1});
    send_pixel(in_item_t'{10'd1023, 10'd1023, 16'd65535});
    send_pixel(in_item_t'{10'd512, 10'd512, 16'd0});

    probe(SET_NOMINAL, 0, 8);
    probe(SET_ZERO_UNITS, 4, 3);
    probe(SET_BIG_UNITS, 4, 3);
    probe(SET_NEG_LIMITS, 4, 2);
    probe(SET_EMPTY_WINDOW, 4, 2);
    probe(SET_ALL_ONES, 4, 2);
    probe(SET_CORNER_COEFS, 4, 2);

    goal = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < goal) begin
      load_settings(pick_kind());
      send_phase($urandom_range(40, 200));
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
